FILE: rtl/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg
// Shared types and constants for the policy record deframer: parse phases,
// field kinds, delimiter code units and the parse state, result and slot records.
// ----------------------------------------------------------------------------
`default_nettype none

package prd_pkg;

  localparam logic [31:0] MAGIC_WORD   = 32'h6765_5250;
  localparam logic [7:0]  CU_OPEN      = 8'h5B;
  localparam logic [7:0]  CU_SEP       = 8'h3B;
  localparam logic [7:0]  CU_CLOSE     = 8'h5D;
  localparam logic [31:0] WORD_BYTES   = 32'd4;
  localparam logic [31:0] HEADER_BYTES = 32'd8;
  localparam logic [31:0] SEP_BYTES    = 32'd2;
  localparam logic [31:0] MAGIC_LAST   = 32'd3;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_KEY     = 3'd1;
  localparam logic [2:0] KIND_VALUE   = 3'd2;
  localparam logic [2:0] KIND_TYPE    = 3'd3;
  localparam logic [2:0] KIND_SIZE    = 3'd4;
  localparam logic [2:0] KIND_DATA    = 3'd5;
  localparam logic [2:0] KIND_DELIM   = 3'd6;
  localparam logic [2:0] KIND_OUTSIDE = 3'd7;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_OUTSIDE,
    PH_KEY,
    PH_VALUE,
    PH_TYPE,
    PH_SEP_TYPE,
    PH_SIZE,
    PH_SEP_SIZE,
    PH_DATA,
    PH_SEEK_END,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] byte_count;
    logic        odd_byte;
    logic [7:0]  held_low_byte;
    logic [31:0] word_accumulator;
    logic [31:0] data_remaining;
    logic        error_flag;
  } parse_state_t;

  typedef struct packed {
    logic [2:0]  field_kind;
    logic [7:0]  byte_out;
    logic        field_first;
    logic        field_last;
    logic        record_done;
    logic [31:0] field_word;
    logic        format_error;
  } parse_result_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       file_start;
  } in_slot_t;

  localparam parse_state_t STATE_RESET = '{
    phase:            PH_HEADER,
    byte_count:       32'd0,
    odd_byte:         1'b0,
    held_low_byte:    8'd0,
    word_accumulator: 32'd0,
    data_remaining:   32'd0,
    error_flag:       1'b0
  };

endpackage

`default_nettype wire

FILE: rtl/policy_record_deframer.sv
// an accepted input byte passes the input register, then the result register
// throughput: one byte per cycle while the output is not stalled, set by the
// combinational parse step between the input register and the result register
// reset: rst (synchronous) empties both registers and returns the parser to
// the header phase; file_start on a byte does the same for the parse state
// ----------------------------------------------------------------------------
// policy_record_deframer
// Tags each byte of a policy file with its field kind and field marks,
// checks the header magic and assembles the type and size words.
// ----------------------------------------------------------------------------
`default_nettype none

module policy_record_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        file_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       field_kind,
  output logic [7:0]       byte_out,
  output logic             field_first,
  output logic             field_last,
  output logic             record_done,
  output logic [31:0]      field_word,
  output logic             format_error
);

  prd_pkg::in_slot_t      slot;
  prd_pkg::parse_state_t  state;
  prd_pkg::parse_state_t  state_next;
  prd_pkg::parse_result_t result_next;
  logic                   take;
  logic                   advance;

  // result register frees up when empty or when its transaction is taken
  assign take    = !out_valid || !out_stall;
  assign advance = slot.valid && take;

  prd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .file_start (file_start),
    .take       (take),
    .slot       (slot)
  );

  prd_step u_step (
    .cur        (state),
    .data_byte  (slot.data_byte),
    .file_start (slot.file_start),
    .nxt        (state_next),
    .res        (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= prd_pkg::STATE_RESET;
      out_valid <= 1'b0;
    end else if (advance) begin
      state     <= state_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      field_kind   <= result_next.field_kind;
      byte_out     <= result_next.byte_out;
      field_first  <= result_next.field_first;
      field_last   <= result_next.field_last;
      record_done  <= result_next.record_done;
      field_word   <= result_next.field_word;
      format_error <= result_next.format_error;
    end
  end

  a_done_closes_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_done |-> field_last && field_kind == prd_pkg::KIND_DELIM)
    else $error("record_done without closing delimiter mark");

  a_word_only_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && field_word != 32'd0 |->
      field_last && (field_kind == prd_pkg::KIND_TYPE || field_kind == prd_pkg::KIND_SIZE))
    else $error("field_word set outside the last byte of type or size");

  a_error_outside: assert property (@(posedge clk) disable iff (rst)
    out_valid && format_error && field_kind != prd_pkg::KIND_HEADER |->
      field_kind == prd_pkg::KIND_OUTSIDE && !field_first && !field_last)
    else $error("tagged field after header magic failure");

  a_data_count_live: assert property (@(posedge clk) disable iff (rst)
    state.phase == prd_pkg::PH_DATA |-> state.data_remaining != 32'd0)
    else $error("data phase with nothing left to count");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(field_word) && $stable(field_kind))
    else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: rtl/prd_in_stage.sv
// ----------------------------------------------------------------------------
// prd_in_stage
// Input register of the deframer; holds one byte transaction until the
// parse stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module prd_in_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       data_byte,
  input  wire logic             file_start,
  input  wire logic             take,
  output prd_pkg::in_slot_t     slot
);

  // slot drains whenever the next stage can take it
  assign in_stall = slot.valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else if (!in_stall) begin
      slot.valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      slot.data_byte  <= data_byte;
      slot.file_start <= file_start;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/prd_step.sv
// ----------------------------------------------------------------------------
// prd_step
// One-byte parse step: from the current parse state and one input byte,
// computes the next state and the tagged result.
// ----------------------------------------------------------------------------
`default_nettype none

module prd_step (
  input  wire prd_pkg::parse_state_t  cur,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   file_start,
  output prd_pkg::parse_state_t       nxt,
  output prd_pkg::parse_result_t      res
);

  prd_pkg::parse_state_t s;
  logic [31:0] cnt_inc;
  logic [31:0] acc_shift;
  logic [31:0] rem_dec;
  logic        unit_hi_zero;

  always_comb begin
    s            = file_start ? prd_pkg::STATE_RESET : cur;
    nxt          = s;
    cnt_inc      = s.byte_count + 32'd1;
    acc_shift    = {data_byte, s.word_accumulator[31:8]};
    rem_dec      = s.data_remaining - 32'd1;
    unit_hi_zero = s.odd_byte && (data_byte == 8'd0);

    res.field_kind  = prd_pkg::KIND_OUTSIDE;
    res.byte_out    = data_byte;
    res.field_first = 1'b0;
    res.field_last  = 1'b0;
    res.record_done = 1'b0;
    res.field_word  = 32'd0;

    case (s.phase)
      prd_pkg::PH_HEADER: begin
        res.field_kind       = prd_pkg::KIND_HEADER;
        res.field_first      = (s.byte_count == 32'd0);
        nxt.word_accumulator = acc_shift;
        nxt.byte_count       = cnt_inc;
        if (s.byte_count == prd_pkg::MAGIC_LAST && acc_shift != prd_pkg::MAGIC_WORD) begin
          nxt.error_flag = 1'b1;
        end
        if (cnt_inc >= prd_pkg::HEADER_BYTES) begin
          res.field_last = 1'b1;
          nxt.phase      = nxt.error_flag ? prd_pkg::PH_ERROR : prd_pkg::PH_OUTSIDE;
          nxt.byte_count = 32'd0;
          nxt.odd_byte   = 1'b0;
        end
      end
      prd_pkg::PH_OUTSIDE: begin
        nxt.odd_byte      = !s.odd_byte;
        nxt.held_low_byte = s.odd_byte ? s.held_low_byte : data_byte;
        if (unit_hi_zero && s.held_low_byte == prd_pkg::CU_OPEN) begin
          nxt.phase      = prd_pkg::PH_KEY;
          nxt.byte_count = 32'd0;
          nxt.odd_byte   = 1'b0;
        end
      end
      prd_pkg::PH_KEY, prd_pkg::PH_VALUE: begin
        res.field_kind    = (s.phase == prd_pkg::PH_KEY) ? prd_pkg::KIND_KEY
                                                         : prd_pkg::KIND_VALUE;
        res.field_first   = (s.byte_count == 32'd0);
        nxt.byte_count    = cnt_inc;
        nxt.odd_byte      = !s.odd_byte;
        nxt.held_low_byte = s.odd_byte ? s.held_low_byte : data_byte;
        // text ends on a ';' code unit with a zero high byte
        if (unit_hi_zero && s.held_low_byte == prd_pkg::CU_SEP) begin
          res.field_last = 1'b1;
          nxt.byte_count = 32'd0;
          nxt.odd_byte   = 1'b0;
          if (s.phase == prd_pkg::PH_KEY) begin
            nxt.phase = prd_pkg::PH_VALUE;
          end else begin
            nxt.phase            = prd_pkg::PH_TYPE;
            nxt.word_accumulator = 32'd0;
          end
        end
      end
      prd_pkg::PH_TYPE, prd_pkg::PH_SIZE: begin
        res.field_kind       = (s.phase == prd_pkg::PH_TYPE) ? prd_pkg::KIND_TYPE
                                                             : prd_pkg::KIND_SIZE;
        res.field_first      = (s.byte_count == 32'd0);
        nxt.word_accumulator = acc_shift;
        nxt.byte_count       = cnt_inc;
        if (cnt_inc >= prd_pkg::WORD_BYTES) begin
          res.field_last = 1'b1;
          res.field_word = acc_shift;
          if (s.phase == prd_pkg::PH_SIZE) begin
            nxt.data_remaining = acc_shift;
          end
          nxt.phase            = (s.phase == prd_pkg::PH_TYPE) ? prd_pkg::PH_SEP_TYPE
                                                               : prd_pkg::PH_SEP_SIZE;
          nxt.byte_count       = 32'd0;
          nxt.odd_byte         = 1'b0;
          nxt.word_accumulator = 32'd0;
        end
      end
      prd_pkg::PH_SEP_TYPE, prd_pkg::PH_SEP_SIZE: begin
        res.field_kind  = prd_pkg::KIND_DELIM;
        res.field_first = (s.byte_count == 32'd0);
        nxt.byte_count  = cnt_inc;
        if (cnt_inc >= prd_pkg::SEP_BYTES) begin
          res.field_last = 1'b1;
          nxt.byte_count = 32'd0;
          nxt.odd_byte   = 1'b0;
          if (s.phase == prd_pkg::PH_SEP_TYPE) begin
            nxt.phase = prd_pkg::PH_SIZE;
          end else begin
            nxt.phase = (s.data_remaining != 32'd0) ? prd_pkg::PH_DATA
                                                    : prd_pkg::PH_SEEK_END;
          end
        end
      end
      prd_pkg::PH_DATA: begin
        res.field_kind     = prd_pkg::KIND_DATA;
        res.field_first    = (s.byte_count == 32'd0);
        nxt.byte_count     = cnt_inc;
        nxt.data_remaining = rem_dec;
        if (rem_dec == 32'd0) begin
          res.field_last = 1'b1;
          nxt.phase      = prd_pkg::PH_SEEK_END;
          nxt.byte_count = 32'd0;
          nxt.odd_byte   = 1'b0;
        end
      end
      prd_pkg::PH_SEEK_END: begin
        res.field_kind    = prd_pkg::KIND_DELIM;
        res.field_first   = (s.byte_count == 32'd0);
        nxt.byte_count    = cnt_inc;
        nxt.odd_byte      = !s.odd_byte;
        nxt.held_low_byte = s.odd_byte ? s.held_low_byte : data_byte;
        if (unit_hi_zero && s.held_low_byte == prd_pkg::CU_CLOSE) begin
          res.field_last  = 1'b1;
          res.record_done = 1'b1;
          nxt.phase       = prd_pkg::PH_OUTSIDE;
          nxt.byte_count  = 32'd0;
          nxt.odd_byte    = 1'b0;
        end
      end
      default: begin
        // error phase: bytes pass as outside record until the next file
      end
    endcase

    res.format_error = nxt.error_flag;
  end

endmodule

`default_nettype wire
